// ===== hdl/preproc_char_tokenizer_macros.svh =====
// assertion macros for the preprocessor character tokenizer
`ifndef PREPROC_CHAR_TOKENIZER_MACROS_SVH
`define PREPROC_CHAR_TOKENIZER_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define PCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// next-cycle implication, checked on every clock edge outside reset
`define PCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

// ===== hdl/pct_pkg.sv =====
// types and constants shared by the preprocessor character tokenizer
package pct_pkg;

   typedef enum logic [2:0] {
      TOK_EOF    = 3'd0,
      TOK_HASH   = 3'd1,
      TOK_LPAREN = 3'd2,
      TOK_RPAREN = 3'd3,
      TOK_WS     = 3'd4,
      TOK_TEXT   = 3'd5
   } token_kind_type;

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_WS   = 2'd1,
      RUN_TEXT = 2'd2
   } run_kind_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   localparam int FIELD_BITS = 16;

   typedef struct packed {
      token_kind_type          kind;
      logic [FIELD_BITS-1:0]   index;
      logic [FIELD_BITS-1:0]   row;
      logic [FIELD_BITS-1:0]   column;
      logic [FIELD_BITS-1:0]   length;
      logic                    last;
   } token_type;

endpackage

// ===== hdl/preproc_char_tokenizer.sv =====
// preprocessor character tokenizer: byte stream in, tokens out
//
//  channel | direction | payload                                      | notes
//  req_    | in        | byte_value, end_of_buffer                    | one byte per beat
//  rsp_    | out       | token_kind, start_index/row/column, length,  | zero to two beats
//          |           | last_of_item                                 | per request beat
//
// one request beat is taken per cycle while the token queue has room for two tokens;
// the tokenizer state and the queue write are updated in the same cycle as the beat
// a request beat that emits tokens shows its first token on rsp_ the next cycle at the
// earliest, behind any tokens still waiting in the queue
// the 4-entry token queue sets the rate: with rsp_ready held high a request beat
// every cycle runs until two-token beats fill the queue, one token leaves per cycle
// synchronous reset empties the queue and returns the position and run state
// to the start of a buffer; an end mark resets only the position and run state, after its tokens
`include "preproc_char_tokenizer_macros.svh"

module preproc_char_tokenizer
   import pct_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_start_index,
   output logic [15:0] rsp_start_row,
   output logic [15:0] rsp_start_column,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_item
);

   localparam int P = POSITION_BITS;
   localparam logic [P-1:0] POS_ONE = P'(1);

   // saturating increment at the top of the position range
   function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
      if (&v) begin
         return v;
      end
      return v + POS_ONE;
   endfunction

   // clip a position value into a 16-bit output field
   function automatic logic [FIELD_BITS-1:0] clip16(input logic [P-1:0] v);
      logic [P+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, v};
      if (wide > (P+FIELD_BITS)'({FIELD_BITS{1'b1}})) begin
         return {FIELD_BITS{1'b1}};
      end
      return wide[FIELD_BITS-1:0];
   endfunction

   // tokenizer state
   logic [P-1:0]  pos_ff,      pos_in;
   logic [P-1:0]  row_ff,      row_in;
   logic [P-1:0]  col_ff,      col_in;
   logic          first_ff,    first_in;
   run_kind_type  run_kind_ff, run_kind_in;
   logic [P-1:0]  run_len_ff,  run_len_in;
   logic [P-1:0]  run_idx_ff,  run_idx_in;
   logic [P-1:0]  run_row_ff,  run_row_in;
   logic [P-1:0]  run_col_ff,  run_col_in;

   // token queue
   token_type     queue_ff [4];
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [2:0]    count_ff,  count_in;

   logic          req_beat;
   logic          rsp_beat;
   logic          is_ws, is_special, is_nul, is_text;
   logic          extend;
   logic          flush_valid, single_valid;
   logic [1:0]    push_count;
   token_type     flush_tok, single_tok;
   token_type     push_first, push_second;
   token_type     head;
   logic [P-1:0]  byte_row, byte_col;
   token_kind_type single_kind;
   logic          at_start;

   assign req_ready = (count_ff <= 3'd2);
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_beat  = rsp_valid && rsp_ready;

   // byte class
   assign is_ws      = (req_byte_value == CHAR_NEWLINE) || (req_byte_value == CHAR_TAB) ||
                       (req_byte_value == CHAR_SPACE);
   assign is_special = (req_byte_value == CHAR_HASH) || (req_byte_value == CHAR_LPAREN) ||
                       (req_byte_value == CHAR_RPAREN);
   assign is_nul     = (req_byte_value == CHAR_NUL);
   assign is_text    = !is_ws && !is_special && !is_nul;

   // position of this byte: first byte stays at row 1 column 1, newline moves to column 0
   always_comb begin
      byte_row = row_ff;
      byte_col = col_ff;
      if (!first_ff) begin
         if (req_byte_value == CHAR_NEWLINE) begin
            byte_row = sat_inc(row_ff);
            byte_col = '0;
         end else begin
            byte_col = sat_inc(col_ff);
         end
      end
   end

   // a byte of the same class as the open run only grows it
   assign extend = !req_end_of_buffer &&
                   (((run_kind_ff == RUN_WS) && is_ws) ||
                    ((run_kind_ff == RUN_TEXT) && is_text));

   assign flush_valid  = (run_kind_ff != RUN_NONE) && !extend;
   assign single_valid = req_end_of_buffer || is_nul || is_special;

   always_comb begin
      case (req_byte_value)
         CHAR_HASH:   single_kind = TOK_HASH;
         CHAR_LPAREN: single_kind = TOK_LPAREN;
         CHAR_RPAREN: single_kind = TOK_RPAREN;
         default:     single_kind = TOK_EOF;
      endcase
      if (req_end_of_buffer) begin
         single_kind = TOK_EOF;
      end
   end

   always_comb begin
      flush_tok.kind   = (run_kind_ff == RUN_WS) ? TOK_WS : TOK_TEXT;
      flush_tok.index  = clip16(run_idx_ff);
      flush_tok.row    = clip16(run_row_ff);
      flush_tok.column = clip16(run_col_ff);
      flush_tok.length = clip16(run_len_ff);
      flush_tok.last   = !single_valid;

      single_tok.kind  = single_kind;
      single_tok.index = clip16(pos_ff);
      single_tok.last  = 1'b1;
      if (req_end_of_buffer) begin
         // end mark eof sits one column past the last byte
         single_tok.row    = clip16(row_ff);
         single_tok.column = first_ff ? clip16(col_ff) : clip16(sat_inc(col_ff));
      end else begin
         single_tok.row    = clip16(byte_row);
         single_tok.column = clip16(byte_col);
      end
      single_tok.length = (single_kind == TOK_EOF) ? '0 : FIELD_BITS'(1);

      push_first  = flush_valid ? flush_tok : single_tok;
      push_second = single_tok;
      push_count  = {1'b0, flush_valid} + {1'b0, single_valid};
   end

   // next tokenizer state
   always_comb begin
      pos_in      = pos_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      first_in    = first_ff;
      run_kind_in = run_kind_ff;
      run_len_in  = run_len_ff;
      run_idx_in  = run_idx_ff;
      run_row_in  = run_row_ff;
      run_col_in  = run_col_ff;
      if (req_beat) begin
         if (req_end_of_buffer) begin
            // back to the start of a buffer
            pos_in      = '0;
            row_in      = POS_ONE;
            col_in      = POS_ONE;
            first_in    = 1'b1;
            run_kind_in = RUN_NONE;
            run_len_in  = '0;
            run_idx_in  = '0;
            run_row_in  = '0;
            run_col_in  = '0;
         end else begin
            pos_in   = sat_inc(pos_ff);
            row_in   = byte_row;
            col_in   = byte_col;
            first_in = 1'b0;
            if (extend) begin
               run_len_in = sat_inc(run_len_ff);
            end else if (is_ws || is_text) begin
               run_kind_in = is_ws ? RUN_WS : RUN_TEXT;
               run_len_in  = POS_ONE;
               run_idx_in  = pos_ff;
               run_row_in  = byte_row;
               run_col_in  = byte_col;
            end else begin
               run_kind_in = RUN_NONE;
               run_len_in  = '0;
            end
         end
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_beat) begin
         wr_ptr_in = wr_ptr_ff + push_count;
         count_in  = count_in + {1'b0, push_count};
      end
      if (rsp_beat) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         count_in  = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         row_ff      <= POS_ONE;
         col_ff      <= POS_ONE;
         first_ff    <= 1'b1;
         run_kind_ff <= RUN_NONE;
         run_len_ff  <= '0;
         run_idx_ff  <= '0;
         run_row_ff  <= '0;
         run_col_ff  <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         first_ff    <= first_in;
         run_kind_ff <= run_kind_in;
         run_len_ff  <= run_len_in;
         run_idx_ff  <= run_idx_in;
         run_row_ff  <= run_row_in;
         run_col_ff  <= run_col_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_beat && (push_count != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= push_first;
      end
      if (req_beat && (push_count == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= push_second;
      end
   end

   assign head             = queue_ff[rd_ptr_ff];
   assign rsp_token_kind   = head.kind;
   assign rsp_start_index  = head.index;
   assign rsp_start_row    = head.row;
   assign rsp_start_column = head.column;
   assign rsp_token_length = head.length;
   assign rsp_last_of_item = head.last;

   // start of a fresh buffer
   assign at_start = first_ff && (pos_ff == '0) && (run_kind_ff == RUN_NONE);

   // queue never holds more than its four entries
   `PCT_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= 3'd4)
   // a beat that emits nothing is a whitespace or text byte opening or growing a run
   `PCT_ASSERT_NOW(a_silent_beat, clock, reset, req_beat && push_count == 2'd0, is_ws || is_text)
   // an end mark leaves the block at the start of a fresh buffer
   `PCT_ASSERT_NEXT(a_end_clears, clock, reset, req_beat && req_end_of_buffer, at_start)

endmodule
